FILE: design/ppb_pkg.sv
package ppb_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPOS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASSLESS = 3'd5;

    localparam logic [1:0] ACT_DELETE  = 2'd0;
    localparam logic [1:0] ACT_REFLECT = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_STOP    = 2'd3;

    localparam logic [1:0] KIND_LOWER = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_WALL  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [24:0] INVG_ONE   = 25'h100_0000;
    localparam logic [31:0] ONE_Q24    = 32'h0100_0000;
    localparam logic [63:0] ONE_SQ_Q48 = 64'h0001_0000_0000_0000;

    localparam int SQ_STAGES = 16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         kind;
        logic signed [31:0] bpos;
        logic [31:0]        dt;
        logic [1:0]         axis;
        logic               massless;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               del;
        logic               ehit;
        logic [31:0]        weight;
        logic               last;
    } t_pay;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_isq;

    function automatic t_isq isq_step(input t_isq s, input logic [63:0] bitv);
        t_isq        o;
        logic [63:0] t;
        t = s.root + bitv;
        if (s.rem >= t) begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + bitv;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] o;
        if (v > 34'sd2147483647) begin
            o = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            o = 32'sh8000_0000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

endpackage

FILE: design/ppb_sqrt.sv
module ppb_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_rad,
    output logic        o_valid,
    output logic [31:0] o_root
);
    import ppb_pkg::*;

    t_isq r_st [1:SQ_STAGES];
    logic r_v  [1:SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        localparam logic [63:0] B0 = 64'd1 << (62 - 4 * g);
        localparam logic [63:0] B1 = 64'd1 << (60 - 4 * g);
        t_isq s_st;
        logic s_v;
        t_isq n_st;
        if (g == 0) begin : g_src
            assign s_st = '{rem: i_rad, root: 64'd0};
            assign s_v  = i_valid;
        end else begin : g_src
            assign s_st = r_st[g];
            assign s_v  = r_v[g];
        end
        always_comb begin
            n_st = isq_step(isq_step(s_st, B0), B1);
        end
        always_ff @(posedge i_clk) begin
            r_st[g+1] <= n_st;
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= s_v;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES];
    assign o_root  = r_st[SQ_STAGES].root[31:0];

endmodule

FILE: design/ppb_front.sv
module ppb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppb_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic signed [31:0]  i_position,
    input  logic signed [31:0]  i_mom_x,
    input  logic signed [31:0]  i_mom_y,
    input  logic signed [31:0]  i_mom_z,
    input  logic [31:0]         i_particle_weight,
    input  logic [24:0]         i_inverse_gamma,
    input  logic                i_last_in_batch,
    output logic                o_valid,
    output ppb_pkg::t_pay       o_pay,
    output logic [63:0]         o_rad
);
    import ppb_pkg::*;

    // stage 1: drift speed, squares
    logic               r1_v;
    logic signed [31:0] r1_pos, r1_px, r1_py, r1_pz;
    logic [31:0]        r1_w;
    logic               r1_last;
    logic [31:0]        r1_spd;
    logic [31:0]        r1_pnm;
    logic               r1_pns;
    logic [62:0]        r1_sq [0:2];

    logic signed [31:0] n1_pn;
    logic [24:0]        n1_invg;
    logic [56:0]        n1_vprod;
    logic [31:0]        n1_m [0:2];
    logic [63:0]        n1_sq [0:2];

    always_comb begin
        if (i_cfg.axis == AXIS_X) begin
            n1_pn = i_mom_x;
        end else if (i_cfg.axis == AXIS_Y) begin
            n1_pn = i_mom_y;
        end else begin
            n1_pn = i_mom_z;
        end
        n1_invg  = (i_inverse_gamma > INVG_ONE) ? INVG_ONE : i_inverse_gamma;
        n1_vprod = 57'(i_cfg.dt) * 57'(n1_invg);
        n1_m[0]  = i_mom_x[31] ? 32'(-i_mom_x) : i_mom_x;
        n1_m[1]  = i_mom_y[31] ? 32'(-i_mom_y) : i_mom_y;
        n1_m[2]  = i_mom_z[31] ? 32'(-i_mom_z) : i_mom_z;
        for (int k = 0; k < 3; k++) begin
            n1_sq[k] = 64'(n1_m[k]) * 64'(n1_m[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pos  <= i_position;
        r1_px   <= i_mom_x;
        r1_py   <= i_mom_y;
        r1_pz   <= i_mom_z;
        r1_w    <= i_particle_weight;
        r1_last <= i_last_in_batch;
        r1_spd  <= n1_vprod[55:24];
        r1_pnm  <= n1_pn[31] ? 32'(-n1_pn) : n1_pn;
        r1_pns  <= n1_pn[31];
        for (int k = 0; k < 3; k++) begin
            r1_sq[k] <= n1_sq[k][62:0];
        end
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end

    // stage 2: displacement, sum of squares
    logic               r2_v;
    logic signed [31:0] r2_pos, r2_px, r2_py, r2_pz;
    logic [31:0]        r2_w;
    logic               r2_last;
    logic [31:0]        r2_d;
    logic               r2_pns;
    logic [63:0]        r2_s;

    logic [63:0] n2_dprod;

    assign n2_dprod = 64'(r1_spd) * 64'(r1_pnm);

    always_ff @(posedge i_clk) begin
        r2_pos  <= r1_pos;
        r2_px   <= r1_px;
        r2_py   <= r1_py;
        r2_pz   <= r1_pz;
        r2_w    <= r1_w;
        r2_last <= r1_last;
        r2_d    <= n2_dprod[63:32];
        r2_pns  <= r1_pns;
        r2_s    <= 64'(r1_sq[0]) + 64'(r1_sq[1]) + 64'(r1_sq[2])
                   + (i_cfg.massless ? 64'd0 : ONE_SQ_Q48);
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    // stage 3: hit test and action
    logic        r3_v;
    t_pay        r3_pay;
    logic [63:0] r3_rad;

    logic signed [33:0] n3_disp, n3_old, n3_b, n3_pos, n3_mir;
    logic               n3_hit;
    logic signed [31:0] n3_pn, n3_neg;
    t_pay               n3_pay;

    always_comb begin
        n3_b    = 34'(i_cfg.bpos);
        n3_pos  = 34'(r2_pos);
        n3_disp = r2_pns ? -$signed({2'b00, r2_d}) : $signed({2'b00, r2_d});
        n3_old  = n3_pos - n3_disp;
        n3_mir  = (n3_b <<< 1) - n3_pos;
        case (i_cfg.kind)
            KIND_LOWER: n3_hit = n3_pos < n3_b;
            KIND_UPPER: n3_hit = n3_pos >= n3_b;
            KIND_WALL:  n3_hit = (n3_old < n3_b && n3_pos > n3_b)
                              || (n3_old > n3_b && n3_pos < n3_b);
            default:    n3_hit = 1'b0;
        endcase
        if (i_cfg.axis == AXIS_X) begin
            n3_pn = r2_px;
        end else if (i_cfg.axis == AXIS_Y) begin
            n3_pn = r2_py;
        end else begin
            n3_pn = r2_pz;
        end
        n3_neg = (n3_pn == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -n3_pn;

        n3_pay.pos    = r2_pos;
        n3_pay.px     = r2_px;
        n3_pay.py     = r2_py;
        n3_pay.pz     = r2_pz;
        n3_pay.del    = 1'b0;
        n3_pay.ehit   = 1'b0;
        n3_pay.weight = r2_w;
        n3_pay.last   = r2_last;
        if (n3_hit) begin
            case (i_cfg.mode)
                ACT_DELETE: begin
                    n3_pay.del = 1'b1;
                end
                ACT_REFLECT: begin
                    n3_pay.pos = sat32(n3_mir);
                    if (i_cfg.axis == AXIS_X) begin
                        n3_pay.px = n3_neg;
                    end else if (i_cfg.axis == AXIS_Y) begin
                        n3_pay.py = n3_neg;
                    end else begin
                        n3_pay.pz = n3_neg;
                    end
                end
                ACT_REMOVE: begin
                    n3_pay.del  = 1'b1;
                    n3_pay.ehit = 1'b1;
                end
                default: begin
                    n3_pay.pos  = sat32(n3_mir);
                    n3_pay.px   = '0;
                    n3_pay.py   = '0;
                    n3_pay.pz   = '0;
                    n3_pay.ehit = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pay <= n3_pay;
        r3_rad <= r2_s;
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    assign o_valid = r3_v;
    assign o_pay   = r3_pay;
    assign o_rad   = r3_rad;

endmodule

FILE: design/planar_particle_boundary.sv
// Start to o_valid: 3 front stages (drift, squares, hit/action), 16 square
// root stages at two result bits each, 1 energy multiply stage.
// Throughput: one particle per cycle; o_busy stays low, nothing stalls.
// Reset (synchronous, active low) clears all valid bits and config registers.
// Results are not held: the receiver takes each one in its strobe cycle.
module planar_particle_boundary (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [31:0]           i_position,
    input  logic signed [31:0]           i_mom_x,
    input  logic signed [31:0]           i_mom_y,
    input  logic signed [31:0]           i_mom_z,
    input  logic [31:0]                  i_particle_weight,
    input  logic [24:0]                  i_inverse_gamma,
    input  logic                         i_last_in_batch,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ppb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output logic                         o_valid,
    output logic signed [31:0]           o_new_position,
    output logic signed [31:0]           o_new_mom_x,
    output logic signed [31:0]           o_new_mom_y,
    output logic signed [31:0]           o_new_mom_z,
    output logic                         o_delete_flag,
    output logic [47:0]                  o_energy_lost,
    output logic                         o_batch_end
);
    import ppb_pkg::*;

    t_cfg r_cfg;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACTION:   r_cfg.mode     <= i_cfg_data[1:0];
                CFG_KIND:     r_cfg.kind     <= i_cfg_data[1:0];
                CFG_BPOS:     r_cfg.bpos     <= i_cfg_data;
                CFG_DT:       r_cfg.dt       <= i_cfg_data;
                CFG_AXIS:     r_cfg.axis     <= i_cfg_data[1:0];
                CFG_MASSLESS: r_cfg.massless <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic        f_valid;
    t_pay        f_pay;
    logic [63:0] f_rad;

    ppb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_start && !o_busy),
        .i_position        (i_position),
        .i_mom_x           (i_mom_x),
        .i_mom_y           (i_mom_y),
        .i_mom_z           (i_mom_z),
        .i_particle_weight (i_particle_weight),
        .i_inverse_gamma   (i_inverse_gamma),
        .i_last_in_batch   (i_last_in_batch),
        .o_valid           (f_valid),
        .o_pay             (f_pay),
        .o_rad             (f_rad)
    );

    logic        s_valid;
    logic [31:0] s_root;

    ppb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .o_valid (s_valid),
        .o_root  (s_root)
    );

    t_pay r_dly [0:SQ_STAGES-1];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= f_pay;
        for (int k = 1; k < SQ_STAGES; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // energy stage
    t_pay        r_out;
    logic [47:0] r_energy;
    logic        r_ov;

    logic [31:0] n_e;
    logic [63:0] n_prod;

    always_comb begin
        n_e    = r_cfg.massless ? s_root : s_root - ONE_Q24;
        n_prod = 64'(r_dly[SQ_STAGES-1].weight) * 64'(n_e);
    end

    always_ff @(posedge i_clk) begin
        r_out    <= r_dly[SQ_STAGES-1];
        r_energy <= r_dly[SQ_STAGES-1].ehit ? n_prod[63:16] : 48'd0;
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= s_valid;
        end
    end

    assign o_valid        = r_ov;
    assign o_new_position = r_out.pos;
    assign o_new_mom_x    = r_out.px;
    assign o_new_mom_y    = r_out.py;
    assign o_new_mom_z    = r_out.pz;
    assign o_delete_flag  = r_out.del;
    assign o_energy_lost  = r_energy;
    assign o_batch_end    = r_out.last;

`ifndef SYNTH
    a_no_energy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cfg.mode == ACT_DELETE || r_cfg.mode == ACT_REFLECT)
        |-> o_energy_lost == 48'd0)
        else $error("energy reported for delete or reflect");

    a_stop_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cfg.mode == ACT_STOP || r_cfg.mode == ACT_REFLECT)
        |-> !o_delete_flag)
        else $error("particle deleted under stop or reflect");

    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
`endif

endmodule
